[design/stpl_pkg.sv]
// Shared types and constants of the slot table with linear probing.
package stpl_pkg;

   localparam int SLOT_COUNT = 64;
   localparam int IDX_W = 6;
   localparam int TAG_W = 31;
   localparam int CNT_W = 7;
   localparam int OP_W = 2;
   localparam int STATUS_W = 3;

   localparam int ACTIVE_LIMIT_INT = (SLOT_COUNT < 64) ? SLOT_COUNT : 64;
   localparam logic [CNT_W-1:0] ACTIVE_LIMIT = CNT_W'(ACTIVE_LIMIT_INT);
   localparam logic [CNT_W-1:0] SLOTS_RESET = 7'd64;
   localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(SLOT_COUNT - 1);

   typedef enum logic [OP_W-1:0] {
      OP_INSERT,
      OP_REMOVE,
      OP_MOVE,
      OP_LIST
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK,
      STAT_PROBED,
      STAT_FULL,
      STAT_NOT_FOUND,
      STAT_OCCUPIED,
      STAT_BAD_INDEX
   } status_type;

   typedef struct packed {
      logic             shift;
      logic             wr_en;
      logic [TAG_W-1:0] wr_tag;
   } ring_ctl_type;

endpackage

[design/slot_table_linear_probe_core.sv]
// Top level of the slot table: command sequencer around the rotating ring of slot cells.
//
// A command rejected for a bad index or a zero insert tag answers in the cycle after it
// is taken. Remove, list, a failed move, a full insert and an insert that lands in or after
// its preferred slot take one ring revolution plus a decision state. An insert that wraps
// below its preferred slot and a successful move need a second revolution. busy is high
// until the final word is strobed, and a new command is taken in the cycle after busy falls;
// no command is taken while busy. The ring moves one slot past the head cell per cycle
// during a revolution. A rejected command never raises busy, so the next one can be taken
// at the following edge.
// Reset (synchronous, active high) empties every slot and sets the slot count register to 64.
// Result words are strobed on rsp_valid for one cycle each; the receiver cannot stall them.
module slot_table_linear_probe_core
   import stpl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [OP_W-1:0]     req_op,
   input  logic [TAG_W-1:0]    req_tag,
   input  logic [IDX_W-1:0]    req_slot_index,
   input  logic [IDX_W-1:0]    req_target_index,
   input  logic                csr_wr_en,
   input  logic [CNT_W-1:0]    csr_wr_data,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [IDX_W-1:0]    rsp_slot_out,
   output logic [TAG_W-1:0]    rsp_tag_out,
   output logic                rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PASS1,
      ST_DECIDE,
      ST_PASS2
   } state_type;

   // Configuration register and the clamped count of active slots.
   logic [CNT_W-1:0] slots_ff;
   logic [CNT_W-1:0] slots_in;
   logic [CNT_W-1:0] n_act;

   assign slots_in = csr_wr_en ? csr_wr_data : slots_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= SLOTS_RESET;
      end else begin
         slots_ff <= slots_in;
      end
   end

   always_comb begin
      if (slots_ff == '0) begin
         n_act = CNT_W'(1);
      end else if (slots_ff > ACTIVE_LIMIT) begin
         n_act = ACTIVE_LIMIT;
      end else begin
         n_act = slots_ff;
      end
   end

   // Sequencer state. The step counter names the slot now sitting in the head cell; every
   // revolution shifts each slot once past the head, so the ring is back in place whenever idle.
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] step_ff, step_in;
   op_type           op_ff, op_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [IDX_W-1:0] src_ff, src_in;
   logic [IDX_W-1:0] dst_ff, dst_in;
   logic [TAG_W-1:0] src_tag_ff, src_tag_in;
   logic [TAG_W-1:0] dst_tag_ff, dst_tag_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] hit_ff, hit_in;
   logic             low_valid_ff, low_valid_in;
   logic [IDX_W-1:0] low_ff, low_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0] pend_slot_ff, pend_slot_in;
   logic [TAG_W-1:0] pend_tag_ff, pend_tag_in;

   // Result word registers.
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [TAG_W-1:0] rsp_tag_ff, rsp_tag_in;
   logic             rsp_last_ff, rsp_last_in;

   ring_ctl_type     ring_ctl;
   logic [TAG_W-1:0] head_tag;
   logic             head_active;
   logic             src_ok;
   logic             dst_ok;

   stpl_ring u_ring (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ring_ctl),
      .head_tag (head_tag)
   );

   assign head_active = {1'b0, step_ff} < n_act;
   assign src_ok = {1'b0, req_slot_index} < n_act;
   assign dst_ok = {1'b0, req_target_index} < n_act;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      op_in         = op_ff;
      tag_in        = tag_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      src_tag_in    = src_tag_ff;
      dst_tag_in    = dst_tag_ff;
      found_in      = found_ff;
      hit_in        = hit_ff;
      low_valid_in  = low_valid_ff;
      low_in        = low_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_tag_in   = pend_tag_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_last_in   = rsp_last_ff;
      ring_ctl      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in         = op_type'(req_op);
               tag_in        = req_tag;
               src_in        = req_slot_index;
               dst_in        = req_target_index;
               step_in       = '0;
               found_in      = 1'b0;
               low_valid_in  = 1'b0;
               pend_valid_in = 1'b0;
               // Range and zero-tag checks answer at once without touching the ring.
               if ((op_type'(req_op) == OP_INSERT && (!src_ok || req_tag == '0)) ||
                   (op_type'(req_op) == OP_REMOVE && !src_ok) ||
                   (op_type'(req_op) == OP_MOVE && (!src_ok || !dst_ok))) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_BAD_INDEX;
                  rsp_slot_in   = (op_type'(req_op) == OP_MOVE && src_ok) ?
                                  req_target_index : req_slot_index;
                  rsp_tag_in    = '0;
                  rsp_last_in   = 1'b1;
               end else begin
                  state_in = ST_PASS1;
               end
            end
         end

         ST_PASS1: begin
            ring_ctl.shift = 1'b1;
            step_in = step_ff + IDX_W'(1);
            case (op_ff)
               OP_INSERT: begin
                  if (step_ff == src_ff) begin
                     src_tag_in = head_tag;
                  end
                  // First empty slot at or after the preferred one is written on the fly;
                  // the first empty one below it is only remembered for a second revolution.
                  if (head_active && head_tag == '0) begin
                     if (step_ff >= src_ff && !found_ff) begin
                        ring_ctl.wr_en  = 1'b1;
                        ring_ctl.wr_tag = tag_ff;
                        found_in        = 1'b1;
                        hit_in          = step_ff;
                     end else if (step_ff < src_ff && !low_valid_ff) begin
                        low_valid_in = 1'b1;
                        low_in       = step_ff;
                     end
                  end
               end
               OP_REMOVE: begin
                  if (step_ff == src_ff) begin
                     src_tag_in = head_tag;
                     if (head_tag == tag_ff) begin
                        ring_ctl.wr_en  = 1'b1;
                        ring_ctl.wr_tag = '0;
                     end
                  end
               end
               OP_MOVE: begin
                  if (step_ff == src_ff) begin
                     src_tag_in = head_tag;
                  end
                  if (step_ff == dst_ff) begin
                     dst_tag_in = head_tag;
                  end
               end
               OP_LIST: begin
                  // Each occupied slot is held back one find so the final one can carry last.
                  if (head_active && head_tag != '0) begin
                     if (pend_valid_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_OK;
                        rsp_slot_in   = pend_slot_ff;
                        rsp_tag_in    = pend_tag_ff;
                        rsp_last_in   = 1'b0;
                     end
                     pend_valid_in = 1'b1;
                     pend_slot_in  = step_ff;
                     pend_tag_in   = head_tag;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
            if (step_ff == LAST_STEP) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            state_in    = ST_IDLE;
            rsp_last_in = 1'b1;
            case (op_ff)
               OP_INSERT: begin
                  if (found_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = (hit_ff == src_ff) ? STAT_OK : STAT_PROBED;
                     rsp_slot_in   = hit_ff;
                     rsp_tag_in    = tag_ff;
                  end else if (low_valid_ff) begin
                     state_in = ST_PASS2;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_FULL;
                     rsp_slot_in   = src_ff;
                     rsp_tag_in    = src_tag_ff;
                  end
               end
               OP_REMOVE: begin
                  rsp_valid_in = 1'b1;
                  rsp_slot_in  = src_ff;
                  if (src_tag_ff == tag_ff) begin
                     rsp_status_in = STAT_OK;
                     rsp_tag_in    = '0;
                  end else begin
                     rsp_status_in = STAT_NOT_FOUND;
                     rsp_tag_in    = src_tag_ff;
                  end
               end
               OP_MOVE: begin
                  if (src_tag_ff != tag_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_NOT_FOUND;
                     rsp_slot_in   = src_ff;
                     rsp_tag_in    = src_tag_ff;
                  end else if (dst_tag_ff != '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_OCCUPIED;
                     rsp_slot_in   = dst_ff;
                     rsp_tag_in    = dst_tag_ff;
                  end else begin
                     state_in = ST_PASS2;
                  end
               end
               OP_LIST: begin
                  rsp_valid_in = 1'b1;
                  if (pend_valid_ff) begin
                     rsp_status_in = STAT_OK;
                     rsp_slot_in   = pend_slot_ff;
                     rsp_tag_in    = pend_tag_ff;
                  end else begin
                     rsp_status_in = STAT_NOT_FOUND;
                     rsp_slot_in   = '0;
                     rsp_tag_in    = '0;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b0;
               end
            endcase
         end

         ST_PASS2: begin
            ring_ctl.shift = 1'b1;
            step_in = step_ff + IDX_W'(1);
            if (op_ff == OP_INSERT) begin
               if (step_ff == low_ff) begin
                  ring_ctl.wr_en  = 1'b1;
                  ring_ctl.wr_tag = tag_ff;
               end
            end else begin
               // Move: the target write wins when source and target coincide.
               if (step_ff == dst_ff) begin
                  ring_ctl.wr_en  = 1'b1;
                  ring_ctl.wr_tag = tag_ff;
               end else if (step_ff == src_ff) begin
                  ring_ctl.wr_en  = 1'b1;
                  ring_ctl.wr_tag = '0;
               end
            end
            if (step_ff == LAST_STEP) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_tag_in    = tag_ff;
               rsp_last_in   = 1'b1;
               if (op_ff == OP_INSERT) begin
                  rsp_status_in = STAT_PROBED;
                  rsp_slot_in   = low_ff;
               end else begin
                  rsp_status_in = STAT_OK;
                  rsp_slot_in   = dst_ff;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         found_ff      <= 1'b0;
         low_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         found_ff      <= found_in;
         low_valid_ff  <= low_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff         <= op_in;
      tag_ff        <= tag_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      src_tag_ff    <= src_tag_in;
      dst_tag_ff    <= dst_tag_in;
      hit_ff        <= hit_in;
      low_ff        <= low_in;
      pend_slot_ff  <= pend_slot_in;
      pend_tag_ff   <= pend_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_slot_out = rsp_slot_ff;
   assign rsp_tag_out  = rsp_tag_ff;
   assign rsp_last     = rsp_last_ff;

   // The ring must be back in its home position whenever no command is in flight.
   a_ring_home: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> step_ff == '0)
      else $error("ring not aligned while idle");

   // Only the words of a list that are followed by another one leave last low.
   a_last_only_list: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == STAT_OK && op_ff == OP_LIST)
      else $error("intermediate word outside a list");

   // A taken command either starts a revolution or is rejected at once.
   a_start_acts: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("command dropped");

   // A second insert revolution only runs when a wrapped empty slot was found.
   a_pass2_insert: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PASS2 && op_ff == OP_INSERT |-> low_valid_ff && !found_ff)
      else $error("second insert revolution without a target");

endmodule

[design/stpl_cell.sv]
// One slot cell of the rotating ring: holds a tag and takes its neighbor's tag on a shift.
module stpl_cell
   import stpl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             shift,
   input  logic [TAG_W-1:0] d_tag,
   output logic [TAG_W-1:0] q_tag
);

   logic [TAG_W-1:0] tag_ff;
   logic [TAG_W-1:0] tag_in;

   assign tag_in = shift ? d_tag : tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

   assign q_tag = tag_ff;

endmodule

[design/stpl_ring.sv]
// Ring of slot cells; the head cell is read and its word re-enters at the tail, optionally replaced.
module stpl_ring
   import stpl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  ring_ctl_type     ctl,
   output logic [TAG_W-1:0] head_tag
);

   logic [TAG_W-1:0] cell_q [SLOT_COUNT];
   logic [TAG_W-1:0] tail_d;

   // The slot leaving the head wraps to the tail, replaced when a write is due.
   assign tail_d = ctl.wr_en ? ctl.wr_tag : cell_q[0];

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      logic [TAG_W-1:0] d_tag;
      if (i == SLOT_COUNT - 1) begin : g_tail
         assign d_tag = tail_d;
      end else begin : g_body
         assign d_tag = cell_q[i+1];
      end
      stpl_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (ctl.shift),
         .d_tag (d_tag),
         .q_tag (cell_q[i])
      );
   end

   assign head_tag = cell_q[0];

endmodule

[test/slot_table_linear_probe_core_test.sv]
// Self-checking testbench of slot_table_linear_probe_core with its own slot table predictor.
module slot_table_linear_probe_core_test;
   import stpl_pkg::*;

   // One table command as it goes out on the req_ ports.
   typedef struct {
      op_type           op;
      logic [TAG_W-1:0] tag;
      logic [IDX_W-1:0] slot;
      logic [IDX_W-1:0] target;
   } table_cmd_type;

   // One result word as it should appear on the rsp_ ports.
   typedef struct {
      status_type       status;
      logic [IDX_W-1:0] slot;
      logic [TAG_W-1:0] tag;
      logic             last;
   } table_word_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_op = '0;
   logic [TAG_W-1:0]    req_tag = '0;
   logic [IDX_W-1:0]    req_slot_index = '0;
   logic [IDX_W-1:0]    req_target_index = '0;
   logic                csr_wr_en = 1'b0;
   logic [CNT_W-1:0]    csr_wr_data = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [IDX_W-1:0]    rsp_slot_out;
   logic [TAG_W-1:0]    rsp_tag_out;
   logic                rsp_last;

   // Commands waiting for the driver, and result words still owed by the block.
   table_cmd_type  cmd_queue[$];
   table_word_type expected_words[$];

   // The predictor's private copy of the table and of the slot count register.
   logic [TAG_W-1:0] shadow_tags[SLOT_COUNT];
   logic [CNT_W-1:0] shadow_slots_cfg;
   // A copy of the table that the stimulus generator reads; it is updated with a
   // nonblocking assignment so that reading it at a rising edge is race free.
   logic [TAG_W-1:0] slot_view[SLOT_COUNT];

   int   mismatch_count = 0;
   int   idle_pct = 0;        // chance in percent that the sender skips a cycle
   int   gen_slots = SLOT_COUNT;
   logic taken = 1'b0;        // the word on req_ was accepted at the last rising edge
   logic hold_for_drain = 1'b0;

   slot_table_linear_probe_core DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_tag          (req_tag),
      .req_slot_index   (req_slot_index),
      .req_target_index (req_target_index),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_slot_out     (rsp_slot_out),
      .rsp_tag_out      (rsp_tag_out),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The register value is clamped to the range of slots the 6-bit fields can name.
   function automatic int active_slots(input logic [CNT_W-1:0] value);
      int n;
      n = value;
      if (n < 1) n = 1;
      if (n > ACTIVE_LIMIT_INT) n = ACTIVE_LIMIT_INT;
      return n;
   endfunction

   function automatic void expect_word(input status_type status, input int slot,
                                       input logic [TAG_W-1:0] tag, input logic last);
      table_word_type w;
      w.status = status;
      w.slot   = IDX_W'(slot);
      w.tag    = tag;
      w.last   = last;
      expected_words.push_back(w);
   endfunction

   // Applies one accepted command to the shadow table and queues the words it causes.
   function automatic void apply_table_cmd(input table_cmd_type c);
      int             n;
      int             j;
      int             s;
      int             free_slot;
      table_word_type held;
      logic           have_held;
      n = active_slots(shadow_slots_cfg);
      case (c.op)
         OP_INSERT: begin
            if (c.slot >= n || c.tag == '0) begin
               expect_word(STAT_BAD_INDEX, c.slot, '0, 1'b1);
            end else if (shadow_tags[c.slot] == '0) begin
               shadow_tags[c.slot] = c.tag;
               expect_word(STAT_OK, c.slot, c.tag, 1'b1);
            end else begin
               // Walk forward from the preferred slot, wrapping to slot 0 at the
               // active count, and remember the first empty slot met.
               free_slot = -1;
               j = c.slot;
               for (s = 1; s < n; s++) begin
                  j = (j + 1 >= n) ? 0 : j + 1;
                  if (free_slot < 0 && shadow_tags[j] == '0) free_slot = j;
               end
               if (free_slot >= 0) begin
                  shadow_tags[free_slot] = c.tag;
                  expect_word(STAT_PROBED, free_slot, c.tag, 1'b1);
               end else begin
                  expect_word(STAT_FULL, c.slot, shadow_tags[c.slot], 1'b1);
               end
            end
         end
         OP_REMOVE: begin
            if (c.slot >= n) begin
               expect_word(STAT_BAD_INDEX, c.slot, '0, 1'b1);
            end else if (shadow_tags[c.slot] == c.tag) begin
               shadow_tags[c.slot] = '0;
               expect_word(STAT_OK, c.slot, '0, 1'b1);
            end else begin
               expect_word(STAT_NOT_FOUND, c.slot, shadow_tags[c.slot], 1'b1);
            end
         end
         OP_MOVE: begin
            if (c.slot >= n || c.target >= n) begin
               expect_word(STAT_BAD_INDEX, (c.slot >= n) ? c.slot : c.target, '0, 1'b1);
            end else if (shadow_tags[c.slot] != c.tag) begin
               expect_word(STAT_NOT_FOUND, c.slot, shadow_tags[c.slot], 1'b1);
            end else if (shadow_tags[c.target] != '0) begin
               expect_word(STAT_OCCUPIED, c.target, shadow_tags[c.target], 1'b1);
            end else begin
               shadow_tags[c.slot] = '0;
               shadow_tags[c.target] = c.tag;
               expect_word(STAT_OK, c.target, c.tag, 1'b1);
            end
         end
         default: begin
            // A list holds back each word until the next occupied slot shows up,
            // so that the final one can carry the last flag.
            have_held = 1'b0;
            for (j = 0; j < n; j++) begin
               if (shadow_tags[j] != '0) begin
                  if (have_held) expected_words.push_back(held);
                  held.status = STAT_OK;
                  held.slot   = IDX_W'(j);
                  held.tag    = shadow_tags[j];
                  held.last   = 1'b0;
                  have_held   = 1'b1;
               end
            end
            if (have_held) begin
               held.last = 1'b1;
               expected_words.push_back(held);
            end else begin
               expect_word(STAT_NOT_FOUND, 0, '0, 1'b1);
            end
         end
      endcase
   endfunction

   // Rising edge: check the result word first, since a word strobed at the edge
   // where a new command is taken still belongs to an older command; then track
   // register writes and accepted commands.
   always @(posedge clock) begin
      table_word_type w;
      table_cmd_type  c;
      if (reset) begin
         for (int k = 0; k < SLOT_COUNT; k++) shadow_tags[k] = '0;
         shadow_slots_cfg = SLOTS_RESET;
         expected_words.delete();
         taken <= 1'b0;
      end else begin
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word: status %0d slot %0d tag %h last %b",
                        $time, rsp_status, rsp_slot_out, rsp_tag_out, rsp_last);
               mismatch_count++;
            end else begin
               w = expected_words.pop_front();
               if (rsp_status !== w.status || rsp_slot_out !== w.slot ||
                   rsp_tag_out !== w.tag || rsp_last !== w.last) begin
                  $display("%0t: mismatch: expected status %0d slot %0d tag %h last %b, %s",
                           $time, w.status, w.slot, w.tag, w.last, "got");
                  $display("%0t:           actual   status %0d slot %0d tag %h last %b",
                           $time, rsp_status, rsp_slot_out, rsp_tag_out, rsp_last);
                  mismatch_count++;
               end
            end
         end
         if (csr_wr_en) shadow_slots_cfg = csr_wr_data;
         if (start && !busy) begin
            c.op     = op_type'(req_op);
            c.tag    = req_tag;
            c.slot   = req_slot_index;
            c.target = req_target_index;
            apply_table_cmd(c);
         end
         taken <= start && !busy;
      end
      slot_view <= shadow_tags;
   end

   // Falling edge: the driver. A word on req_ stays put until it has been taken;
   // after that the next queued command goes out unless the sender idles this cycle.
   // Now and then the driver holds back until the block owes no more words.
   always @(negedge clock) begin
      table_cmd_type c;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken) begin
         if (hold_for_drain) begin
            if (expected_words.size() == 0) hold_for_drain <= 1'b0;
            start <= 1'b0;
         end else if (cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
            if ($urandom_range(19) == 0) begin
               hold_for_drain <= 1'b1;
               start <= 1'b0;
            end else begin
               c = cmd_queue.pop_front();
               start            <= 1'b1;
               req_op           <= c.op;
               req_tag          <= c.tag;
               req_slot_index   <= c.slot;
               req_target_index <= c.target;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   function automatic void add_cmd(input op_type op, input logic [TAG_W-1:0] tag,
                                   input int slot, input int target);
      table_cmd_type c;
      c.op     = op;
      c.tag    = tag;
      c.slot   = IDX_W'(slot);
      c.target = IDX_W'(target);
      cmd_queue.push_back(c);
   endfunction

   // Returns at a rising edge once nothing is queued, in flight or owed.
   task automatic wait_idle();
      do @(posedge clock);
      while (cmd_queue.size() != 0 || start || expected_words.size() != 0 || busy);
   endtask

   // The register is only written while the block is idle.
   task automatic configure_slots(input logic [CNT_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      gen_slots = active_slots(value);
   endtask

   // Owner tags lean toward the extremes now and then; zero is never produced here.
   function automatic logic [TAG_W-1:0] random_tag();
      logic [TAG_W-1:0] t;
      case ($urandom_range(9))
         0: t = 31'd1;
         1: t = 31'h7FFF_FFFF;
         default: t = TAG_W'($urandom);
      endcase
      if (t == '0) t = 31'd1;
      return t;
   endfunction

   // Builds one command from the current table contents. Most removes and moves
   // name a slot that is occupied and its real tag, so that they get past the
   // tag check; the rest are random and mostly miss.
   task automatic make_random_cmd(output table_cmd_type c);
      int occupied[$];
      int pick;
      int r;
      for (int k = 0; k < gen_slots; k++) if (slot_view[k] != '0) occupied.push_back(k);
      r = $urandom_range(99);
      c.target = IDX_W'($urandom_range(63));
      c.slot   = ($urandom_range(9) == 0) ? IDX_W'($urandom_range(63))
                                          : IDX_W'($urandom_range(gen_slots - 1));
      c.tag    = random_tag();
      if (r < 40) begin
         c.op = OP_INSERT;
         if ($urandom_range(19) == 0) c.tag = '0;
      end else if (r < 85) begin
         c.op = (r < 65) ? OP_REMOVE : OP_MOVE;
         if (occupied.size() != 0 && $urandom_range(3) != 0) begin
            pick   = occupied[$urandom_range(occupied.size() - 1)];
            c.slot = IDX_W'(pick);
            c.tag  = slot_view[pick];
         end else if ($urandom_range(9) == 0) begin
            c.tag = '0;
         end
         if (c.op == OP_MOVE && $urandom_range(9) != 0)
            c.target = IDX_W'($urandom_range(gen_slots - 1));
      end else begin
         c.op = OP_LIST;
      end
   endtask

   // One random phase: set the slot count, set the sender's idling, then feed
   // commands one at a time so each is built from the table as it stands.
   task automatic run_random_phase(input logic [CNT_W-1:0] cfg, input int idle,
                                   input int count);
      table_cmd_type c;
      configure_slots(cfg);
      idle_pct = idle;
      repeat (count) begin
         do @(posedge clock);
         while (cmd_queue.size() != 0 || start);
         make_random_cmd(c);
         cmd_queue.push_back(c);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with the slot count at its reset value of 64: an empty
      // list, both tag extremes, an insert at the top slot that must wrap into
      // slot 0, a zero insert tag, a probe, every remove and move outcome but a bad
      // index, including a move onto its own slot, and zero tags on empty slots.
      add_cmd(OP_LIST, 31'd1, 0, 0);
      add_cmd(OP_INSERT, 31'h7FFF_FFFF, 63, 0);
      add_cmd(OP_INSERT, 31'd1, 63, 63);
      add_cmd(OP_INSERT, 31'd0, 5, 0);
      add_cmd(OP_INSERT, 31'h2AAA_AAAA, 0, 0);
      add_cmd(OP_REMOVE, 31'd2, 63, 0);
      add_cmd(OP_MOVE, 31'd1, 0, 63);
      add_cmd(OP_MOVE, 31'd1, 0, 0);
      add_cmd(OP_MOVE, 31'd3, 0, 10);
      add_cmd(OP_MOVE, 31'd1, 0, 10);
      add_cmd(OP_REMOVE, 31'd0, 20, 0);
      add_cmd(OP_MOVE, 31'd0, 30, 31);
      add_cmd(OP_REMOVE, 31'h7FFF_FFFF, 63, 0);
      add_cmd(OP_LIST, 31'h7FFF_FFFF, 63, 63);

      // Two active slots: indexes past the end on insert, remove and move, then a full table.
      configure_slots(7'd2);
      add_cmd(OP_INSERT, 31'd5, 3, 0);
      add_cmd(OP_REMOVE, 31'd5, 63, 0);
      add_cmd(OP_MOVE, 31'd5, 1, 5);
      add_cmd(OP_MOVE, 31'd5, 40, 0);
      add_cmd(OP_INSERT, 31'h5555_5555, 0, 0);
      add_cmd(OP_INSERT, 31'd9, 1, 0);
      add_cmd(OP_LIST, 31'd1, 0, 0);

      // A zero register acts as one slot, and a value past 64 as 64; the slots
      // hidden meanwhile keep their tags.
      configure_slots(7'd0);
      add_cmd(OP_LIST, 31'd1, 0, 0);
      add_cmd(OP_INSERT, 31'd4, 0, 0);
      configure_slots(7'd127);
      add_cmd(OP_LIST, 31'd1, 0, 0);

      run_random_phase(7'd5, 0, 50);
      run_random_phase(7'd127, 47, 60);
      run_random_phase(7'd1, 8, 25);
      run_random_phase(7'd0, 47, 15);
      run_random_phase(7'd17, 8, 50);
      run_random_phase(7'd64, 0, 50);

      // Let the longest command, two ring revolutions, finish well past its end.
      wait_idle();
      repeat (200) @(posedge clock);
      if (expected_words.size() != 0)
         $display("%0t: %0d expected words never arrived", $time, expected_words.size());
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // A watchdog ends the run with an error if it has not finished in time.
   initial begin
      #2000000;
      $display("%0t: timeout", $time);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
